### rtl/pyp_pkg.sv
// ----------------------------------------------------------------------------
// pyp_pkg
// Shared constants, types and the quarter-wave sine generator of the
// yaw-only pinhole projection core.
// ----------------------------------------------------------------------------
package pyp_pkg;

    localparam int DEF_SINE_DEPTH  = 1024;
    localparam int DEF_COORD_WIDTH = 32;
    localparam int TRIG_WIDTH      = 18;
    localparam int TRIG_ONE        = 65536;
    localparam int FOCAL_ONE       = 65536;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_PRINCIPAL_X = 3'd0,
        REG_PRINCIPAL_Y = 3'd1,
        REG_FOCAL_X     = 3'd2,
        REG_FOCAL_Y     = 3'd3,
        REG_SHIFT_X     = 3'd4,
        REG_SHIFT_Y     = 3'd5,
        REG_SHIFT_Z     = 3'd6,
        REG_YAW_ANGLE   = 3'd7
    } pyp_reg_t;

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic big_u;
        logic big_v;
        logic dz;
        logic max_u;
        logic max_v;
    } pyp_side_t;

    // Multiply a Q30 term by theta twice, truncating each time.
    function automatic longint unsigned theta_sq(input longint unsigned term,
                                                 input longint unsigned theta);
        longint unsigned t;
        t = (term * theta) >> 30;
        return (t * theta) >> 30;
    endfunction

    // Q30 Taylor series of sin(theta), rounded to unsigned Q1.16 and capped at one.
    function automatic logic [16:0] quarter_sine(input longint unsigned theta);
        longint unsigned term;
        longint unsigned r;
        longint          sum;
        sum  = longint'(theta);
        term = theta_sq(theta, theta) / 64'd6;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd20;
        sum  = sum + longint'(term);
        term = theta_sq(term, theta) / 64'd42;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd72;
        sum  = sum + longint'(term);
        term = theta_sq(term, theta) / 64'd110;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd156;
        sum  = sum + longint'(term);
        term = theta_sq(term, theta) / 64'd210;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd272;
        sum  = sum + longint'(term);
        term = theta_sq(term, theta) / 64'd342;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd420;
        sum  = sum + longint'(term);
        term = theta_sq(term, theta) / 64'd506;
        sum  = sum - longint'(term);
        term = theta_sq(term, theta) / 64'd600;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[16:0];
    endfunction

endpackage

### rtl/pyp_trig.sv
// ----------------------------------------------------------------------------
// pyp_trig
// Yaw angle to sine and cosine: phase split on a yaw write, then a
// quarter-wave table read into registered signed Q1.16 sine and cosine.
// ----------------------------------------------------------------------------
module pyp_trig
    import pyp_pkg::*;
#(
    parameter int SINE_DEPTH = DEF_SINE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         yaw_we,
    input  logic [15:0]                  yaw_value,
    output logic signed [TRIG_WIDTH-1:0] sin_val,
    output logic signed [TRIG_WIDTH-1:0] cos_val
);

    localparam int FOUR_D = 4 * SINE_DEPTH;
    localparam int MW     = 16 + $clog2(FOUR_D + 1);
    localparam int PW     = $clog2(FOUR_D);
    localparam int KW     = $clog2(SINE_DEPTH + 1);
    localparam logic [PW-1:0] D1 = PW'(SINE_DEPTH);
    localparam logic [PW-1:0] D2 = PW'(2 * SINE_DEPTH);
    localparam logic [PW-1:0] D3 = PW'(3 * SINE_DEPTH);
    localparam logic [KW-1:0] DK = KW'(SINE_DEPTH);

    logic [16:0] rom [0:SINE_DEPTH];

    for (genvar g = 0; g <= SINE_DEPTH; g++) begin : g_rom
        localparam longint unsigned THETA = (PI_HALF_Q30 * g) / SINE_DEPTH;
        localparam logic [16:0] ENTRY = quarter_sine(THETA);
        assign rom[g] = ENTRY;
    end

    logic [MW-1:0]                 prod;
    logic [PW-1:0]                 phase;
    logic [1:0]                    quad_next;
    logic [KW-1:0]                 k_next;
    logic [1:0]                    quad_reg;
    logic [KW-1:0]                 k_reg;
    logic [16:0]                   rom_lo;
    logic [16:0]                   rom_hi;
    logic [TRIG_WIDTH-1:0]         sin_mag;
    logic [TRIG_WIDTH-1:0]         cos_mag;
    logic signed [TRIG_WIDTH-1:0]  sin_next;
    logic signed [TRIG_WIDTH-1:0]  cos_next;
    logic signed [TRIG_WIDTH-1:0]  sin_reg;
    logic signed [TRIG_WIDTH-1:0]  cos_reg;

    always_comb
    begin
        prod  = MW'(yaw_value) * MW'(FOUR_D);
        phase = PW'(prod >> 16);
        priority if (phase >= D3)
        begin
            quad_next = 2'd3;
            k_next    = KW'(phase - D3);
        end
        else if (phase >= D2)
        begin
            quad_next = 2'd2;
            k_next    = KW'(phase - D2);
        end
        else if (phase >= D1)
        begin
            quad_next = 2'd1;
            k_next    = KW'(phase - D1);
        end
        else
        begin
            quad_next = 2'd0;
            k_next    = KW'(phase);
        end
    end

    always_comb
    begin
        rom_lo   = rom[k_reg];
        rom_hi   = rom[DK - k_reg];
        sin_mag  = quad_reg[0] ? {1'b0, rom_hi} : {1'b0, rom_lo};
        cos_mag  = quad_reg[0] ? {1'b0, rom_lo} : {1'b0, rom_hi};
        sin_next = quad_reg[1] ? -$signed(sin_mag) : $signed(sin_mag);
        cos_next = (quad_reg[0] ^ quad_reg[1]) ? -$signed(cos_mag) : $signed(cos_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg <= '0;
            k_reg    <= '0;
            sin_reg  <= '0;
            cos_reg  <= TRIG_WIDTH'(TRIG_ONE);
        end
        else
        begin
            if (yaw_we)
            begin
                quad_reg <= quad_next;
                k_reg    <= k_next;
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### rtl/pyp_div.sv
// ----------------------------------------------------------------------------
// pyp_div
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// The partial remainder at entry must be below the divisor.
// ----------------------------------------------------------------------------
module pyp_div
    import pyp_pkg::*;
#(
    parameter int QW = DEF_COORD_WIDTH,
    parameter int DW = DEF_COORD_WIDTH + 4
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [DW-1:0] den_in,
    output logic [QW-1:0] quot
);

    logic [DW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] nq_reg  [0:QW-1];
    logic [DW-1:0] den_reg [0:QW-2];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] nq_cur;
        logic [DW:0]   shifted;
        logic [DW:0]   trial;

        if (g == 0) begin : g_first
            assign rem_cur = rem_in;
            assign den_cur = den_in;
            assign nq_cur  = num_in;
        end
        else begin : g_next
            assign rem_cur = rem_reg[g-1];
            assign den_cur = den_reg[g-1];
            assign nq_cur  = nq_reg[g-1];
        end

        assign shifted = {rem_cur, nq_cur[QW-1]};
        assign trial   = shifted - {1'b0, den_cur};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= trial[DW] ? shifted[DW-1:0] : trial[DW-1:0];
                nq_reg[g]  <= {nq_cur[QW-2:0], ~trial[DW]};
            end
        end

        if (g < QW - 1) begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g] <= den_cur;
                end
            end
        end
    end

    assign quot = nq_reg[QW-1];

endmodule

### rtl/pinhole_yaw_projection_core.sv
// ----------------------------------------------------------------------------
// pinhole_yaw_projection_core
// Yaw-rotated, translated pinhole projection of Q16.16 points to image
// coordinates with zero-depth and range saturation.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one world point per word: point_x, point_y, point_z.
//   m_axis returns one word per point: image_u, image_v in tdata and the
//   depth_zero and overflow flags in tuser.
//   cfg_we/cfg_index/cfg_data write the camera registers; write them only
//   while no point is in flight. A yaw write takes effect for points
//   accepted after it, not for a point accepted in the same cycle.
//   Throughput: one point per cycle while m_axis is not stalled. A point
//   passes capture, rotation, camera-space, numerator and divider-entry
//   stages, the one-bit-per-stage focal*C/Zc divider and the output register.
//   Reset clears all valid bits and loads the register defaults (focal
//   scales 1.0, everything else zero).
//   When m_axis stalls, one extra result lands in a skid register; after
//   that the whole pipeline holds and s_axis_tready drops until the
//   output is taken. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module pinhole_yaw_projection_core
    import pyp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
    parameter int COORD_WIDTH      = DEF_COORD_WIDTH
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // image_u, image_v
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // depth_zero, overflow
    output logic [1:0]                             m_axis_tuser,
    input  logic                                   cfg_we,
    input  logic [2:0]                             cfg_index,
    input  logic [COORD_WIDTH-1:0]                 cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int TW = TRIG_WIDTH;
    localparam int PW = CW + TW;
    localparam int CX = CW + 4;
    localparam int NW = CW + CX;
    localparam int OW = ((2 * CW + 7) / 8) * 8;
    localparam int RW = 2 * CW + 2;
    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    // configuration
    logic signed [CW-1:0] principal_x_reg;
    logic signed [CW-1:0] principal_y_reg;
    logic signed [CW-1:0] focal_x_reg;
    logic signed [CW-1:0] focal_y_reg;
    logic signed [CW-1:0] shift_x_reg;
    logic signed [CW-1:0] shift_y_reg;
    logic signed [CW-1:0] shift_z_reg;
    logic                 yaw_we;
    pyp_reg_t             cfg_sel;

    assign cfg_sel = pyp_reg_t'(cfg_index);
    assign yaw_we  = cfg_we && (cfg_sel == REG_YAW_ANGLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            principal_x_reg <= '0;
            principal_y_reg <= '0;
            focal_x_reg     <= CW'(FOCAL_ONE);
            focal_y_reg     <= CW'(FOCAL_ONE);
            shift_x_reg     <= '0;
            shift_y_reg     <= '0;
            shift_z_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_PRINCIPAL_X: principal_x_reg <= cfg_data;
                REG_PRINCIPAL_Y: principal_y_reg <= cfg_data;
                REG_FOCAL_X:     focal_x_reg     <= cfg_data;
                REG_FOCAL_Y:     focal_y_reg     <= cfg_data;
                REG_SHIFT_X:     shift_x_reg     <= cfg_data;
                REG_SHIFT_Y:     shift_y_reg     <= cfg_data;
                REG_SHIFT_Z:     shift_z_reg     <= cfg_data;
                REG_YAW_ANGLE:   ;
                default:         ;
            endcase
        end
    end

    logic signed [TW-1:0] sin_w;
    logic signed [TW-1:0] cos_w;

    pyp_trig #(
        .SINE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .yaw_we    (yaw_we),
        .yaw_value (cfg_data[15:0]),
        .sin_val   (sin_w),
        .cos_val   (cos_w)
    );

    // pipeline control
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // stage 1: capture
    logic                 v1_reg;
    logic signed [CW-1:0] x1_reg;
    logic signed [CW-1:0] y1_reg;
    logic signed [CW-1:0] z1_reg;

    // stage 2: rotation products
    logic                 v2_reg;
    logic signed [PW-1:0] pxc_reg;
    logic signed [PW-1:0] pzs_reg;
    logic signed [PW-1:0] pzc_reg;
    logic signed [PW-1:0] pxs_reg;
    logic signed [CX-1:0] yc2_reg;

    // stage 3: camera-space point
    logic                 v3_reg;
    logic signed [CX-1:0] xc_reg;
    logic signed [CX-1:0] yc_reg;
    logic signed [CX-1:0] zc_reg;

    // stage 4: numerator magnitudes
    logic                 v4_reg;
    logic [NW-1:0]        nu_reg;
    logic [NW-1:0]        nv_reg;
    logic [CX-1:0]        den4_reg;
    pyp_side_t            side4_next;
    pyp_side_t            side4_reg;
    logic [CW-1:0]        fxm;
    logic [CW-1:0]        fym;
    logic [CX-1:0]        xcm;
    logic [CX-1:0]        ycm;
    logic [CX-1:0]        zcm;

    // stage 5: divider entry
    logic                 v5_reg;
    logic [CX-1:0]        hu;
    logic [CX-1:0]        hv;
    logic [CX-1:0]        remu_reg;
    logic [CX-1:0]        remv_reg;
    logic [CW-1:0]        numu_reg;
    logic [CW-1:0]        numv_reg;
    logic [CX-1:0]        den5_reg;
    pyp_side_t            side5_reg;

    always_comb
    begin
        fxm = focal_x_reg[CW-1] ? CW'(-focal_x_reg) : CW'(focal_x_reg);
        fym = focal_y_reg[CW-1] ? CW'(-focal_y_reg) : CW'(focal_y_reg);
        xcm = xc_reg[CX-1] ? CX'(-xc_reg) : CX'(xc_reg);
        ycm = yc_reg[CX-1] ? CX'(-yc_reg) : CX'(yc_reg);
        zcm = zc_reg[CX-1] ? CX'(-zc_reg) : CX'(zc_reg);
        side4_next.neg_u = focal_x_reg[CW-1] ^ xc_reg[CX-1] ^ zc_reg[CX-1];
        side4_next.neg_v = focal_y_reg[CW-1] ^ yc_reg[CX-1] ^ zc_reg[CX-1];
        side4_next.big_u = 1'b0;
        side4_next.big_v = 1'b0;
        side4_next.dz    = (zc_reg == '0);
        side4_next.max_u = (focal_x_reg == '0) || (xc_reg == '0)
                           || (focal_x_reg[CW-1] == xc_reg[CX-1]);
        side4_next.max_v = (focal_y_reg == '0) || (yc_reg == '0)
                           || (focal_y_reg[CW-1] == yc_reg[CX-1]);
        hu = nu_reg[NW-1:CW];
        hv = nv_reg[NW-1:CW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= s_axis_tdata[CW-1:0];
            y1_reg  <= s_axis_tdata[2*CW-1:CW];
            z1_reg  <= s_axis_tdata[3*CW-1:2*CW];

            pxc_reg <= PW'(x1_reg) * PW'(cos_w);
            pzs_reg <= PW'(z1_reg) * PW'(sin_w);
            pzc_reg <= PW'(z1_reg) * PW'(cos_w);
            pxs_reg <= PW'(x1_reg) * PW'(sin_w);
            yc2_reg <= CX'(y1_reg) + CX'(shift_y_reg);

            xc_reg  <= CX'(shift_x_reg) + CX'(pxc_reg >>> 16) + CX'(pzs_reg >>> 16);
            yc_reg  <= yc2_reg;
            zc_reg  <= CX'(shift_z_reg) + CX'(pzc_reg >>> 16) - CX'(pxs_reg >>> 16);

            nu_reg    <= NW'(fxm) * NW'(xcm);
            nv_reg    <= NW'(fym) * NW'(ycm);
            den4_reg  <= zcm;
            side4_reg <= side4_next;

            remu_reg  <= (hu >= den4_reg) ? '0 : hu;
            remv_reg  <= (hv >= den4_reg) ? '0 : hv;
            numu_reg  <= nu_reg[CW-1:0];
            numv_reg  <= nv_reg[CW-1:0];
            den5_reg  <= den4_reg;
            side5_reg <= '{neg_u: side4_reg.neg_u, neg_v: side4_reg.neg_v,
                           big_u: (hu >= den4_reg), big_v: (hv >= den4_reg),
                           dz: side4_reg.dz, max_u: side4_reg.max_u,
                           max_v: side4_reg.max_v};
        end
    end

    // dividers
    logic [CW-1:0] qu;
    logic [CW-1:0] qv;

    pyp_div #(
        .QW (CW),
        .DW (CX)
    ) u_div_u (
        .clk    (clk),
        .en     (en),
        .rem_in (remu_reg),
        .num_in (numu_reg),
        .den_in (den5_reg),
        .quot   (qu)
    );

    pyp_div #(
        .QW (CW),
        .DW (CX)
    ) u_div_v (
        .clk    (clk),
        .en     (en),
        .rem_in (remv_reg),
        .num_in (numv_reg),
        .den_in (den5_reg),
        .quot   (qv)
    );

    logic      vd_reg   [0:CW-1];
    pyp_side_t side_reg [0:CW-1];

    for (genvar g = 0; g < CW; g++) begin : g_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vd_reg[g] <= (g == 0) ? v5_reg : vd_reg[(g == 0) ? 0 : g - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= (g == 0) ? side5_reg : side_reg[(g == 0) ? 0 : g - 1];
            end
        end
    end

    // finish: sign, zero-depth rails, range check, principal offset, saturation
    function automatic logic [CW:0] finish(
        input logic [CW-1:0]        q,
        input logic                 neg,
        input logic                 big,
        input logic                 dz,
        input logic                 mx,
        input logic signed [CW-1:0] offs
    );
        logic signed [CW+1:0] s;
        logic [CW-1:0]        res;
        logic                 of;
        s = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        s = s + (CW+2)'(offs);
        priority if (dz)
        begin
            res = mx ? MAXV : MINV;
            of  = 1'b0;
        end
        else if (big || (q[CW-1] && (!neg || (q[CW-2:0] != '0))))
        begin
            res = neg ? MINV : MAXV;
            of  = 1'b1;
        end
        else if ((s[CW+1] != s[CW]) || (s[CW] != s[CW-1]))
        begin
            res = s[CW+1] ? MINV : MAXV;
            of  = 1'b1;
        end
        else
        begin
            res = s[CW-1:0];
            of  = 1'b0;
        end
        return {of, res};
    endfunction

    pyp_side_t     sd;
    logic          fin_valid;
    logic [CW:0]   fu;
    logic [CW:0]   fv;
    logic [RW-1:0] res_w;
    logic [RW-1:0] out_reg;
    logic [RW-1:0] skid_reg;
    logic          pop;
    logic          push;

    always_comb
    begin
        sd        = side_reg[CW-1];
        fin_valid = vd_reg[CW-1];
        fu        = finish(qu, sd.neg_u, sd.big_u, sd.dz, sd.max_u, principal_x_reg);
        fv        = finish(qv, sd.neg_v, sd.big_v, sd.dz, sd.max_v, principal_y_reg);
        res_w     = {fu[CW] | fv[CW], sd.dz, fv[CW-1:0], fu[CW-1:0]};
        pop       = out_valid_reg && m_axis_tready;
        push      = en && fin_valid;
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else
            begin
                out_valid_reg <= out_valid_reg && !pop;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_reg <= res_w;
            end
            else
            begin
                skid_reg <= res_w;
            end
        end
        else
        begin
            out_reg <= out_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(out_reg[2*CW-1:0]);
    assign m_axis_tuser  = out_reg[RW-1:2*CW];

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while the output register is empty");

    a_skid_kept: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_axis_tready |=> skid_valid_reg)
        else $error("skid word dropped during a stall");

    a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("overflow flagged on a zero-depth result");

    a_dz_rail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[CW-1:0] == MAXV) || (m_axis_tdata[CW-1:0] == MINV))
        else $error("zero-depth result not on a rail");
`endif

endmodule
